@@ design/phe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package phe_pkg;
  localparam int NumCoeffs = 5;
  localparam int FracBits = 16;
  localparam int CoeffIdxW = $clog2(NumCoeffs);

  localparam logic [2:0] RegMode   = 3'd0;
  localparam logic [2:0] RegOffset = 3'd1;
  localparam logic [2:0] RegScale  = 3'd2;

  localparam logic [1:0] ModePoly = 2'd0;
  localparam logic [1:0] ModeSin  = 2'd1;

  localparam logic signed [31:0] S1 = 32'sd1686629713;
  localparam logic signed [31:0] S3 = 32'sd693598668;
  localparam logic signed [31:0] S5 = 32'sd85569306;
  localparam logic signed [31:0] S7 = 32'sd5026988;
  localparam logic signed [31:0] S9 = 32'sd172271;

  typedef enum logic [3:0] {
    StIdle, StX, StXSum, StCoef, StPow, StSinZ2, StSinH7, StSinH5, StSinH3,
    StSinH1, StSinZ, StSinMul, StNext, StDone
  } state_e;

  // Operands for the shared multiplier.
  typedef struct packed {
    logic signed [34:0] a;
    logic signed [34:0] b;
  } mul_req_t;
endpackage
`default_nettype wire

@@ design/phe_mul.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared signed multiplier with a registered product.
module phe_mul (
  input  wire logic               clk_i,
  input  wire phe_pkg::mul_req_t  req_i,
  output logic signed [69:0]      prod_o
);
  always_ff @(posedge clk_i) begin
    prod_o <= req_i.a * req_i.b;
  end
endmodule
`default_nettype wire

@@ design/polynomial_harmonic_evaluator_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Evaluates a five-term power polynomial or sine/cosine harmonic series at one Q16.16
// sample point per transfer, using a single shared multiplier under a sequencer. An item
// scales its argument, visits each higher coefficient in turn (a chain of products up to
// x^k per nonzero coefficient k in power mode, a sine polynomial per nonzero coefficient
// in harmonic mode) and finishes; the shared multiplier takes one product per cycle. The
// block is not ready while an item is in work, and it holds its last item until the
// output register is free; a result that waits there does not hold back the next input.
module polynomial_harmonic_evaluator_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] sample_point
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] value
  output logic             m_axis_tuser    // [0] overflow
);
  localparam int F = phe_pkg::FracBits;

  logic [1:0] mode_q;
  logic signed [31:0] off_q, scale_q;
  logic signed [31:0] coef_q [phe_pkg::NumCoeffs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= phe_pkg::ModePoly;
      off_q   <= '0;
      scale_q <= 32'sd1 <<< F;
      for (int i = 0; i < phe_pkg::NumCoeffs; i++) coef_q[i] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        phe_pkg::RegMode:   mode_q  <= cfg_data_i[1:0];
        phe_pkg::RegOffset: off_q   <= cfg_data_i;
        phe_pkg::RegScale:  scale_q <= cfg_data_i;
        default: begin
          for (int i = 1; i < phe_pkg::NumCoeffs; i++)
            if (int'(cfg_idx_i) == i + 3) coef_q[i] <= cfg_data_i;
          if (int'(cfg_idx_i) == 3) coef_q[0] <= cfg_data_i;
        end
      endcase
    end
  end

  phe_pkg::state_e state_q, state_d;
  phe_pkg::mul_req_t req;
  logic signed [69:0] prod;
  phe_mul u_mul (.clk_i, .req_i(req), .prod_o(prod));

  logic signed [31:0] t_q, t_d, x_q, x_d, acc_q, acc_d;
  logic signed [35:0] sum_q, sum_d;
  logic signed [31:0] z_q, z_d, z2_q, z2_d;
  logic [2:0] k_q, k_d, i_q, i_d;
  logic quad2_q, quad2_d;
  logic xov_q, xov_d, ov_q, ov_d, xused_q, xused_d;
  logic [31:0] res_q, res_d;
  logic resov_q, resov_d;

  // Rounded Q product and its saturated value.
  logic signed [69:0] rnd;
  logic signed [53:0] rsh;
  logic signed [31:0] rsat;
  logic rovf;
  always_comb begin
    rnd  = prod + (70'sd1 <<< (F - 1));
    rsh  = 54'(rnd >>> F);
    rovf = (rsh > 54'sd2147483647) || (rsh < -54'sd2147483648);
    rsat = rovf ? (rsh[53] ? 32'sh80000000 : 32'sh7fffffff) : rsh[31:0];
  end
  logic signed [39:0] q30;
  assign q30 = 40'(prod >>> 30);

  logic [31:0] u;
  logic [F-1:0] p;
  logic signed [31:0] mag;
  logic signed [39:0] sc;
  logic signed [54:0] fs;

  always_comb begin
    state_d = state_q; t_d = t_q; x_d = x_q; acc_d = acc_q; sum_d = sum_q;
    z_d = z_q; z2_d = z2_q; k_d = k_q; i_d = i_q; quad2_d = quad2_q;
    xov_d = xov_q; ov_d = ov_q; xused_d = xused_q; res_d = res_q; resov_d = resov_q;
    req.a = '0; req.b = '0;
    s_axis_tready = 1'b0;
    p = '0; u = '0; mag = '0; sc = '0; fs = '0;
    case (state_q)
      phe_pkg::StIdle: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          t_d = s_axis_tdata; state_d = phe_pkg::StX;
        end
      end
      phe_pkg::StX: begin
        req.a = 35'(scale_q); req.b = 35'(t_q); state_d = phe_pkg::StXSum;
      end
      phe_pkg::StXSum: begin
        // Offset plus rounded product, saturated to 32 bits.
        fs = 55'(off_q) + 55'(rsh);
        xov_d = (fs > 55'sd2147483647) || (fs < -55'sd2147483648);
        x_d = xov_d ? (fs[54] ? 32'sh80000000 : 32'sh7fffffff) : fs[31:0];
        sum_d = 36'(coef_q[0]); ov_d = 1'b0; xused_d = 1'b0;
        k_d = 3'd1; state_d = phe_pkg::StCoef;
      end
      phe_pkg::StCoef: begin
        if (int'(k_q) >= phe_pkg::NumCoeffs) state_d = phe_pkg::StDone;
        else if (coef_q[k_q[phe_pkg::CoeffIdxW-1:0]] == 0) k_d = k_q + 3'd1;
        else begin
          xused_d = 1'b1;
          acc_d = coef_q[k_q[phe_pkg::CoeffIdxW-1:0]];
          i_d = '0;
          if (mode_q == phe_pkg::ModePoly) begin
            req.a = 35'(coef_q[k_q[phe_pkg::CoeffIdxW-1:0]]); req.b = 35'(x_q);
            state_d = phe_pkg::StPow;
          end else begin
            p = F'(x_q * 32'(k_q));
            u = {p, {(32-F){1'b0}}};
            if (mode_q != phe_pkg::ModeSin) u = u + 32'h40000000;
            quad2_d = u[31];
            z_d = u[30] ? (32'sd1073741824 - {2'b0, u[29:0]}) : {2'b0, u[29:0]};
            state_d = phe_pkg::StSinZ2;
          end
        end
      end
      phe_pkg::StPow: begin
        if (rovf) ov_d = 1'b1;
        if (i_q + 3'd1 == k_q) begin
          sum_d = sum_q + 36'(rsat); state_d = phe_pkg::StNext;
        end else begin
          req.a = 35'(rsat); req.b = 35'(x_q); i_d = i_q + 3'd1;
        end
      end
      phe_pkg::StSinZ2: begin
        req.a = 35'(z_q); req.b = 35'(z_q); state_d = phe_pkg::StSinH7;
        acc_d = phe_pkg::S9;
      end
      phe_pkg::StSinH7: begin
        z2_d = q30[31:0];
        req.a = 35'(acc_q); req.b = 35'(q30[31:0]); state_d = phe_pkg::StSinH5;
      end
      phe_pkg::StSinH5: begin
        acc_d = phe_pkg::S7 - q30[31:0];
        req.a = 35'(phe_pkg::S7 - q30[31:0]); req.b = 35'(z2_q); state_d = phe_pkg::StSinH3;
      end
      phe_pkg::StSinH3: begin
        req.a = 35'(phe_pkg::S5 - q30[31:0]); req.b = 35'(z2_q); state_d = phe_pkg::StSinH1;
      end
      phe_pkg::StSinH1: begin
        req.a = 35'(phe_pkg::S3 - q30[31:0]); req.b = 35'(z2_q); state_d = phe_pkg::StSinZ;
      end
      phe_pkg::StSinZ: begin
        req.a = 35'(phe_pkg::S1 - q30[31:0]); req.b = 35'(z_q); state_d = phe_pkg::StSinMul;
      end
      phe_pkg::StSinMul: begin
        sc = q30;
        if (sc > 40'sd1073741824) sc = 40'sd1073741824;
        if (sc < 0) sc = '0;
        mag = 32'((sc + (40'sd1 <<< (29 - F))) >>> (30 - F));
        if (quad2_q) mag = -mag;
        req.a = 35'(coef_q[k_q[phe_pkg::CoeffIdxW-1:0]]); req.b = 35'(mag);
        acc_d = coef_q[k_q[phe_pkg::CoeffIdxW-1:0]];
        state_d = phe_pkg::StNext;
      end
      phe_pkg::StNext: begin
        // After a harmonic term the coefficient product is ready in this cycle.
        if (mode_q != phe_pkg::ModePoly) sum_d = sum_q + 36'(rsh);
        k_d = k_q + 3'd1; state_d = phe_pkg::StCoef;
      end
      phe_pkg::StDone: begin
        resov_d = ov_q | (xused_q & xov_q);
        if (sum_q > 36'sd2147483647) begin res_d = 32'h7fffffff; resov_d = 1'b1; end
        else if (sum_q < -36'sd2147483648) begin res_d = 32'h80000000; resov_d = 1'b1; end
        else res_d = sum_q[31:0];
        if (!m_axis_tvalid || m_axis_tready) state_d = phe_pkg::StIdle;
        else state_d = phe_pkg::StDone;
        if (m_axis_tvalid && !m_axis_tready) begin res_d = res_q; resov_d = resov_q; end
      end
      default: state_d = phe_pkg::StIdle;
    endcase
  end

  logic val_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= phe_pkg::StIdle; val_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == phe_pkg::StDone && (!val_q || m_axis_tready)) val_q <= 1'b1;
      else if (m_axis_tready) val_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d; x_q <= x_d; acc_q <= acc_d; sum_q <= sum_d; z_q <= z_d; z2_q <= z2_d;
    k_q <= k_d; i_q <= i_d; quad2_q <= quad2_d; xov_q <= xov_d; ov_q <= ov_d;
    xused_q <= xused_d;
    if (state_q != phe_pkg::StDone || !val_q || m_axis_tready) begin
      res_q <= res_d; resov_q <= resov_d;
    end
  end

  assign m_axis_tvalid = val_q;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = resov_q;
endmodule
`default_nettype wire
